[src/psg_pkg.sv]
// Package for the prime session guard: codes, widths and shared types.
// Depends on nothing; every module of the block imports it.
package psg_pkg;

    localparam int SESSION_HISTORY = 8;
    localparam int HOLD_HISTORY    = 8;
    localparam int SH_IW = (SESSION_HISTORY > 1) ? $clog2(SESSION_HISTORY) : 1;
    localparam int HH_IW = (HOLD_HISTORY > 1) ? $clog2(HOLD_HISTORY) : 1;
    localparam int SH_CW = $clog2(SESSION_HISTORY + 1);
    localparam int HH_CW = $clog2(HOLD_HISTORY + 1);

    localparam logic [31:0] LEASE_GRACE_RESET = 32'd3000;

    localparam logic [3:0] ACT_ACTIVATE  = 4'd0;
    localparam logic [3:0] ACT_QUERY     = 4'd1;
    localparam logic [3:0] ACT_CANCEL    = 4'd2;
    localparam logic [3:0] ACT_HSTART    = 4'd3;
    localparam logic [3:0] ACT_HTICK     = 4'd4;
    localparam logic [3:0] ACT_HSTOP     = 4'd5;
    localparam logic [3:0] ACT_PSTARTED  = 4'd6;
    localparam logic [3:0] ACT_PREFUSED  = 4'd7;
    localparam logic [3:0] ACT_PSTOPPED  = 4'd8;
    localparam logic [3:0] ACT_LEASE     = 4'd9;

    localparam logic [1:0] PH_OFF   = 2'd0;
    localparam logic [1:0] PH_READY = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;

    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_FRONT  = 2'd1;
    localparam logic [1:0] SRC_FAUCET = 2'd2;
    localparam logic [1:0] SRC_ODD    = 2'd3;

    localparam logic [2:0] OUT_STOPPED = 3'd1;
    localparam logic [2:0] OUT_REFUSED = 3'd2;

    localparam logic [2:0] DEC_IGNORE  = 3'd0;
    localparam logic [2:0] DEC_START   = 3'd1;
    localparam logic [2:0] DEC_REFRESH = 3'd2;
    localparam logic [2:0] DEC_STOP    = 3'd3;
    localparam logic [2:0] DEC_RECSTOP = 3'd4;

    typedef struct packed {
        logic [3:0]  action;
        logic [1:0]  source;
        logic [7:0]  channel;
        logic [31:0] session_tok;
        logic [31:0] hold_tok;
        logic [31:0] now_time_ms;
        logic [2:0]  outcome_in;
        logic [31:0] elapsed_in;
        logic        tombstone_off;
    } item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  decision;
        logic        lease_expired;
        logic [1:0]  phase;
        logic [7:0]  channel;
        logic [1:0]  owner;
        logic [2:0]  outcome;
        logic [31:0] elapsed;
        logic [31:0] session_tok;
        logic [31:0] hold_tok;
        logic [31:0] revision;
    } result_t;

endpackage

[src/psg_front.sv]
// Front part: accepts items, folds source three into none, and queues them.
// Depends on psg_pkg.
module psg_front
    import psg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  q_valid,
    input  logic  q_ready,
    output item_t q_item
);
    // two-entry queue
    item_t      mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      norm;
    logic       push, pop;

    always_comb
    begin
        norm = in_item;
        if (in_item.source == SRC_ODD)
        begin
            norm.source = SRC_NONE;
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= norm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

[src/psg_back.sv]
// Back part: history scans over cycles, session update, result register.
// Depends on psg_pkg.
module psg_back
    import psg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    input  logic [31:0] grace,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;
    item_t  it_reg;

    logic [31:0] sess_hist [SESSION_HISTORY];
    logic [31:0] hold_hist [2][HOLD_HISTORY];
    logic [SH_CW-1:0] sh_cnt_reg;
    logic [SH_IW-1:0] sh_nxt_reg;
    logic [HH_CW-1:0] hh_cnt_reg [2];
    logic [HH_IW-1:0] hh_nxt_reg [2];

    // scan position covers both rings; one entry of each per cycle
    localparam int SCW = $clog2((SESSION_HISTORY > HOLD_HISTORY ?
                                 SESSION_HISTORY : HOLD_HISTORY) + 1);
    localparam int SCAN_LEN = SESSION_HISTORY > HOLD_HISTORY ?
                              SESSION_HISTORY : HOLD_HISTORY;
    logic [SCW-1:0] scan_reg;
    logic           sseen_reg, hseen_reg;
    logic           side;

    logic [1:0]  phase_reg;
    logic [7:0]  chan_reg;
    logic [1:0]  owner_reg;
    logic [2:0]  outc_reg;
    logic [31:0] elap_reg, stok_reg, htok_reg, rev_reg, stamp_reg;

    logic        rv_reg;
    result_t     res_reg;

    assign side      = (it_reg.source == SRC_FAUCET);
    assign q_ready   = (state_reg == ST_IDLE) && (!rv_reg || res_ready);
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid && q_ready) state_next = ST_SCAN;
            ST_SCAN: if (scan_reg == SCW'(SCAN_LEN - 1)) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // execution of one item
    logic        acc, sess_rem, hold_rem, do_bump, clr_hold;
    logic [2:0]  dec;
    logic [1:0]  ph_n, own_n;
    logic [7:0]  ch_n;
    logic [2:0]  oc_n;
    logic [31:0] el_n, st_n, ht_n, stamp_n, rev_n, rev_inc, age;
    logic        match, holder;

    always_comb
    begin
        acc = 1'b0; dec = DEC_IGNORE; sess_rem = 1'b0; hold_rem = 1'b0;
        do_bump = 1'b0; clr_hold = 1'b0;
        ph_n = phase_reg; ch_n = chan_reg; own_n = owner_reg; oc_n = outc_reg;
        el_n = elap_reg; st_n = stok_reg; ht_n = htok_reg; stamp_n = stamp_reg;
        match  = (phase_reg != PH_OFF) && (chan_reg == it_reg.channel)
                 && (stok_reg == it_reg.session_tok);
        holder = (owner_reg == it_reg.source) && (htok_reg == it_reg.hold_tok);
        unique case (it_reg.action)
            ACT_ACTIVATE:
                if (it_reg.channel <= 8'd1 && it_reg.session_tok != 32'd0)
                begin
                    if (match)
                    begin
                        stamp_n = it_reg.now_time_ms; acc = 1'b1;
                    end
                    else if (!sseen_reg && phase_reg == PH_OFF)
                    begin
                        ph_n = PH_READY; ch_n = it_reg.channel; own_n = SRC_NONE;
                        oc_n = 3'd0; el_n = 32'd0; st_n = it_reg.session_tok;
                        ht_n = 32'd0; stamp_n = it_reg.now_time_ms;
                        clr_hold = 1'b1; sess_rem = 1'b1; do_bump = 1'b1;
                        acc = 1'b1;
                    end
                end
            ACT_QUERY:
                if (phase_reg != PH_OFF && it_reg.session_tok != 32'd0
                    && it_reg.session_tok == stok_reg)
                begin
                    stamp_n = it_reg.now_time_ms; acc = 1'b1;
                end
            ACT_CANCEL:
                if (it_reg.session_tok != 32'd0)
                begin
                    if (phase_reg == PH_OFF)
                    begin
                        if (it_reg.tombstone_off)
                        begin
                            if (sseen_reg)
                            begin
                                acc = (stok_reg == it_reg.session_tok);
                            end
                            else
                            begin
                                sess_rem = 1'b1; own_n = SRC_NONE;
                                oc_n = it_reg.outcome_in; el_n = it_reg.elapsed_in;
                                st_n = it_reg.session_tok; ht_n = 32'd0;
                                do_bump = 1'b1; acc = 1'b1;
                            end
                        end
                    end
                    else if (it_reg.session_tok == stok_reg)
                    begin
                        ph_n = PH_OFF; own_n = SRC_NONE; oc_n = it_reg.outcome_in;
                        el_n = it_reg.elapsed_in; do_bump = 1'b1; acc = 1'b1;
                    end
                end
            ACT_HSTART:
                if (it_reg.source != SRC_NONE && it_reg.hold_tok != 32'd0 && match)
                begin
                    if (phase_reg == PH_READY && !hseen_reg)
                    begin
                        hold_rem = 1'b1; dec = DEC_START;
                        if (it_reg.source == SRC_FRONT) stamp_n = it_reg.now_time_ms;
                    end
                    else if (phase_reg == PH_RUN)
                    begin
                        if (holder)
                        begin
                            dec = DEC_REFRESH;
                            if (it_reg.source == SRC_FRONT)
                                stamp_n = it_reg.now_time_ms;
                        end
                        else if (!hseen_reg)
                        begin
                            hold_rem = 1'b1;
                        end
                    end
                end
            ACT_HTICK:
                if (phase_reg == PH_RUN && holder && match)
                begin
                    dec = DEC_REFRESH;
                    if (it_reg.source == SRC_FRONT) stamp_n = it_reg.now_time_ms;
                end
            ACT_HSTOP:
                if (it_reg.source != SRC_NONE && it_reg.hold_tok != 32'd0 && match)
                begin
                    if (phase_reg == PH_RUN)
                    begin
                        if (holder) dec = DEC_STOP;
                    end
                    else if (phase_reg == PH_READY && !hseen_reg)
                    begin
                        hold_rem = 1'b1;
                        if (it_reg.source == SRC_FRONT) stamp_n = it_reg.now_time_ms;
                        own_n = SRC_NONE; oc_n = OUT_STOPPED; el_n = 32'd0;
                        ht_n = it_reg.hold_tok; do_bump = 1'b1; dec = DEC_RECSTOP;
                    end
                end
            ACT_PSTARTED:
                if (phase_reg == PH_READY && it_reg.source != SRC_NONE
                    && it_reg.hold_tok != 32'd0)
                begin
                    ph_n = PH_RUN; own_n = it_reg.source; oc_n = 3'd0;
                    el_n = 32'd0; ht_n = it_reg.hold_tok; do_bump = 1'b1;
                end
            ACT_PREFUSED:
                if (phase_reg == PH_READY && it_reg.hold_tok != 32'd0)
                begin
                    own_n = SRC_NONE; oc_n = OUT_REFUSED; el_n = 32'd0;
                    ht_n = it_reg.hold_tok; do_bump = 1'b1;
                end
            ACT_PSTOPPED:
                if (phase_reg == PH_RUN)
                begin
                    ph_n = PH_READY; own_n = SRC_NONE; oc_n = it_reg.outcome_in;
                    el_n = it_reg.elapsed_in; do_bump = 1'b1;
                end
            default: ;
        endcase
        rev_inc = rev_reg + 32'd1;
        rev_n   = do_bump ? ((rev_inc == 32'd0) ? 32'd1 : rev_inc) : rev_reg;
        age     = it_reg.now_time_ms - stamp_n;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_ready)
        begin
            it_reg <= q_item;
        end
        if (state_reg == ST_EXEC && sess_rem)
        begin
            sess_hist[sh_nxt_reg] <= it_reg.session_tok;
        end
        if (state_reg == ST_EXEC && hold_rem)
        begin
            hold_hist[side][hh_nxt_reg[side]] <= it_reg.hold_tok;
        end
        if (state_reg == ST_EXEC)
        begin
            res_reg <= '{acc, dec, (ph_n != PH_OFF) && (age > grace), ph_n, ch_n,
                         own_n, oc_n, el_n, st_n, ht_n, rev_n};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
            sseen_reg <= 1'b0;
            hseen_reg <= 1'b0;
            rv_reg    <= 1'b0;
            phase_reg <= PH_OFF; chan_reg <= 8'd0; owner_reg <= SRC_NONE;
            outc_reg <= 3'd0; elap_reg <= 32'd0; stok_reg <= 32'd0;
            htok_reg <= 32'd0; rev_reg <= 32'd0; stamp_reg <= 32'd0;
            sh_cnt_reg <= '0; sh_nxt_reg <= '0;
            hh_cnt_reg[0] <= '0; hh_cnt_reg[1] <= '0;
            hh_nxt_reg[0] <= '0; hh_nxt_reg[1] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rv_reg && res_ready) rv_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    scan_reg  <= '0;
                    sseen_reg <= 1'b0;
                    hseen_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + SCW'(1);
                    if (scan_reg < SCW'(SESSION_HISTORY) && scan_reg < sh_cnt_reg
                        && sess_hist[scan_reg[SH_IW-1:0]] == it_reg.session_tok)
                        sseen_reg <= 1'b1;
                    if (scan_reg < SCW'(HOLD_HISTORY) && scan_reg < hh_cnt_reg[side]
                        && hold_hist[side][scan_reg[HH_IW-1:0]] == it_reg.hold_tok)
                        hseen_reg <= 1'b1;
                end
                ST_EXEC:
                begin
                    rv_reg <= 1'b1;
                    phase_reg <= ph_n; chan_reg <= ch_n; owner_reg <= own_n;
                    outc_reg <= oc_n; elap_reg <= el_n; stok_reg <= st_n;
                    htok_reg <= ht_n; rev_reg <= rev_n; stamp_reg <= stamp_n;
                    if (sess_rem)
                    begin
                        sh_nxt_reg <= (sh_nxt_reg == SH_IW'(SESSION_HISTORY - 1))
                                      ? '0 : sh_nxt_reg + SH_IW'(1);
                        if (sh_cnt_reg < SH_CW'(SESSION_HISTORY))
                            sh_cnt_reg <= sh_cnt_reg + SH_CW'(1);
                    end
                    if (clr_hold)
                    begin
                        hh_cnt_reg[0] <= '0; hh_cnt_reg[1] <= '0;
                        hh_nxt_reg[0] <= '0; hh_nxt_reg[1] <= '0;
                    end
                    else if (hold_rem)
                    begin
                        hh_nxt_reg[side] <= (hh_nxt_reg[side] == HH_IW'(HOLD_HISTORY - 1))
                                            ? '0 : hh_nxt_reg[side] + HH_IW'(1);
                        if (hh_cnt_reg[side] < HH_CW'(HOLD_HISTORY))
                            hh_cnt_reg[side] <= hh_cnt_reg[side] + HH_CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[src/prime_session_guard.sv]
// Top level of the prime session guard: front queue, back engine, grace register.
// Depends on psg_pkg, psg_front and psg_back.
//
// Usage:
//   in_valid/in_ready carry one event item (action, source, tokens, time and
//   the outcome fields). out_valid/out_ready return exactly one result item
//   per event: accepted, decision, lease_expired and the session snapshot.
//   cfg_valid/cfg_ready write lease_grace_ms; cfg_ready is always high, and
//   writes belong only to idle periods.
// Operation:
//   A two-entry queue takes items while the back end works. The back end
//   loads an item, scans the histories (the larger of SESSION_HISTORY and
//   HOLD_HISTORY entries, 8 here) comparing one session and one hold entry
//   at a time, and then executes it. It takes no new item until it has
//   executed the last one and its result is taken or being taken.
// Reset:
//   rst_n clears the session to Off, the revision, the lease stamp and all
//   history counts; grace returns to 3000 ms. History contents are not cleared.
// Stall:
//   When out_ready is low the result is held and the back end waits; the
//   front queue keeps taking items until both entries are full.
module prime_session_guard
    import psg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  action,
    input  logic [1:0]  source,
    input  logic [7:0]  channel,
    input  logic [31:0] session_tok,
    input  logic [31:0] hold_tok,
    input  logic [31:0] now_time_ms,
    input  logic [2:0]  outcome_in,
    input  logic [31:0] elapsed_in,
    input  logic        tombstone_off,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [2:0]  decision,
    output logic        lease_expired,
    output logic [1:0]  phase_out,
    output logic [7:0]  channel_out,
    output logic [1:0]  owner_out,
    output logic [2:0]  outcome_out,
    output logic [31:0] elapsed_out,
    output logic [31:0] session_tok_out,
    output logic [31:0] hold_tok_out,
    output logic [31:0] revision_out
);
    item_t       in_item, q_item;
    logic        q_valid, q_ready;
    result_t     res;
    logic [31:0] grace_reg;

    assign in_item = '{action, source, channel, session_tok, hold_tok,
                       now_time_ms, outcome_in, elapsed_in, tombstone_off};

    // hold the lease grace; always ready for a write
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg <= LEASE_GRACE_RESET;
        end
        else if (cfg_valid)
        begin
            grace_reg <= cfg_data;
        end
    end

    psg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    psg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .grace     (grace_reg),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign accepted        = res.accepted;
    assign decision        = res.decision;
    assign lease_expired   = res.lease_expired;
    assign phase_out       = res.phase;
    assign channel_out     = res.channel;
    assign owner_out       = res.owner;
    assign outcome_out     = res.outcome;
    assign elapsed_out     = res.elapsed;
    assign session_tok_out = res.session_tok;
    assign hold_tok_out    = res.hold_tok;
    assign revision_out    = res.revision;
endmodule

[dv/prime_session_guard_tb.sv]
// Self-checking bench for prime_session_guard: directed events, then random
// session flows under three idling profiles. Depends on psg_pkg and the RTL.
`timescale 1ns / 100ps

module prime_session_guard_tb;
    import psg_pkg::*;

    // Predictor of the guard: own copy of the session, lease and histories.
    class guard_scoreboard;
        logic [31:0] grace;
        logic [1:0]  ph;
        logic [7:0]  chan;
        logic [1:0]  own;
        logic [2:0]  outc;
        logic [31:0] elap, stok, htok, rev, stamp;
        logic [31:0] sess_ring [SESSION_HISTORY];
        int          sess_cnt, sess_nxt;
        logic [31:0] hold_ring [2][HOLD_HISTORY];
        int          hold_cnt [2];
        int          hold_nxt [2];
        result_t     pending [$];
        int          errors;

        function new();
            grace = LEASE_GRACE_RESET;
            ph = PH_OFF; chan = 0; own = SRC_NONE; outc = 0;
            elap = 0; stok = 0; htok = 0; rev = 0; stamp = 0;
            sess_cnt = 0; sess_nxt = 0;
            hold_cnt[0] = 0; hold_cnt[1] = 0; hold_nxt[0] = 0; hold_nxt[1] = 0;
            errors = 0;
        endfunction

        function void bump();
            rev = rev + 1;
            if (rev == 0) rev = 1;
        endfunction

        function bit sess_seen(logic [31:0] t);
            for (int i = 0; i < sess_cnt; i++)
                if (sess_ring[i] == t) return 1;
            return 0;
        endfunction

        function void sess_keep(logic [31:0] t);
            sess_ring[sess_nxt] = t;
            sess_nxt = (sess_nxt + 1) % SESSION_HISTORY;
            if (sess_cnt < SESSION_HISTORY) sess_cnt++;
        endfunction

        function bit hold_seen(logic [1:0] s, logic [31:0] t);
            int e;
            e = (s == SRC_FAUCET);
            for (int i = 0; i < hold_cnt[e]; i++)
                if (hold_ring[e][i] == t) return 1;
            return 0;
        endfunction

        function void hold_keep(logic [1:0] s, logic [31:0] t);
            int e;
            e = (s == SRC_FAUCET);
            hold_ring[e][hold_nxt[e]] = t;
            hold_nxt[e] = (hold_nxt[e] + 1) % HOLD_HISTORY;
            if (hold_cnt[e] < HOLD_HISTORY) hold_cnt[e]++;
        endfunction

        function bit live_match(logic [7:0] c, logic [31:0] t);
            return ph != PH_OFF && chan == c && stok == t;
        endfunction

        // Note an accepted event: advance the state and queue its result.
        function void note_event(item_t it);
            result_t r;
            logic [1:0] s;
            logic acc;
            logic [2:0] dec;
            logic [31:0] age;
            s = (it.source == SRC_ODD) ? SRC_NONE : it.source;
            acc = 0; dec = DEC_IGNORE;
            case (it.action)
                ACT_ACTIVATE:
                    if (it.channel <= 1 && it.session_tok != 0)
                    begin
                        if (live_match(it.channel, it.session_tok))
                        begin
                            stamp = it.now_time_ms; acc = 1;
                        end
                        else if (!sess_seen(it.session_tok) && ph == PH_OFF)
                        begin
                            ph = PH_READY; chan = it.channel; own = SRC_NONE;
                            outc = 0; elap = 0; stok = it.session_tok; htok = 0;
                            stamp = it.now_time_ms;
                            hold_cnt[0] = 0; hold_cnt[1] = 0;
                            hold_nxt[0] = 0; hold_nxt[1] = 0;
                            sess_keep(it.session_tok); bump(); acc = 1;
                        end
                    end
                ACT_QUERY:
                    if (ph != PH_OFF && it.session_tok != 0 && it.session_tok == stok)
                    begin
                        stamp = it.now_time_ms; acc = 1;
                    end
                ACT_CANCEL:
                    if (it.session_tok != 0)
                    begin
                        if (ph == PH_OFF)
                        begin
                            if (it.tombstone_off)
                            begin
                                if (sess_seen(it.session_tok))
                                    acc = (stok == it.session_tok);
                                else
                                begin
                                    sess_keep(it.session_tok);
                                    own = SRC_NONE; outc = it.outcome_in;
                                    elap = it.elapsed_in; stok = it.session_tok;
                                    htok = 0; bump(); acc = 1;
                                end
                            end
                        end
                        else if (it.session_tok == stok)
                        begin
                            ph = PH_OFF; own = SRC_NONE; outc = it.outcome_in;
                            elap = it.elapsed_in; bump(); acc = 1;
                        end
                    end
                ACT_HSTART:
                    if (s != SRC_NONE && it.hold_tok != 0
                        && live_match(it.channel, it.session_tok))
                    begin
                        if (ph == PH_READY && !hold_seen(s, it.hold_tok))
                        begin
                            hold_keep(s, it.hold_tok);
                            if (s == SRC_FRONT) stamp = it.now_time_ms;
                            dec = DEC_START;
                        end
                        else if (ph == PH_RUN)
                        begin
                            if (own == s && htok == it.hold_tok)
                            begin
                                if (s == SRC_FRONT) stamp = it.now_time_ms;
                                dec = DEC_REFRESH;
                            end
                            else if (!hold_seen(s, it.hold_tok))
                                hold_keep(s, it.hold_tok);
                        end
                    end
                ACT_HTICK:
                    if (ph == PH_RUN && own == s && htok == it.hold_tok
                        && live_match(it.channel, it.session_tok))
                    begin
                        if (s == SRC_FRONT) stamp = it.now_time_ms;
                        dec = DEC_REFRESH;
                    end
                ACT_HSTOP:
                    if (s != SRC_NONE && it.hold_tok != 0
                        && live_match(it.channel, it.session_tok))
                    begin
                        if (ph == PH_RUN)
                        begin
                            if (own == s && htok == it.hold_tok) dec = DEC_STOP;
                        end
                        else if (ph == PH_READY && !hold_seen(s, it.hold_tok))
                        begin
                            hold_keep(s, it.hold_tok);
                            if (s == SRC_FRONT) stamp = it.now_time_ms;
                            own = SRC_NONE; outc = OUT_STOPPED; elap = 0;
                            htok = it.hold_tok; bump(); dec = DEC_RECSTOP;
                        end
                    end
                ACT_PSTARTED:
                    if (ph == PH_READY && s != SRC_NONE && it.hold_tok != 0)
                    begin
                        ph = PH_RUN; own = s; outc = 0; elap = 0;
                        htok = it.hold_tok; bump();
                    end
                ACT_PREFUSED:
                    if (ph == PH_READY && it.hold_tok != 0)
                    begin
                        own = SRC_NONE; outc = OUT_REFUSED; elap = 0;
                        htok = it.hold_tok; bump();
                    end
                ACT_PSTOPPED:
                    if (ph == PH_RUN)
                    begin
                        ph = PH_READY; own = SRC_NONE; outc = it.outcome_in;
                        elap = it.elapsed_in; bump();
                    end
                default: ;
            endcase
            age = it.now_time_ms - stamp;
            r.accepted = acc; r.decision = dec;
            r.lease_expired = (ph != PH_OFF) && (age > grace);
            r.phase = ph; r.channel = chan; r.owner = own; r.outcome = outc;
            r.elapsed = elap; r.session_tok = stok; r.hold_tok = htok;
            r.revision = rev;
            pending.push_back(r);
        endfunction

        function void report(string what, logic [31:0] e, logic [31:0] a);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %h actual %h", what, e, a);
        endfunction

        // Check one returned result against the oldest prediction.
        function void check_result(result_t got);
            result_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result", 0, got.revision);
                return;
            end
            e = pending.pop_front();
            if (got.accepted !== e.accepted) report("accepted", e.accepted, got.accepted);
            if (got.decision !== e.decision) report("decision", e.decision, got.decision);
            if (got.lease_expired !== e.lease_expired)
                report("lease_expired", e.lease_expired, got.lease_expired);
            if (got.phase !== e.phase) report("phase", e.phase, got.phase);
            if (got.channel !== e.channel) report("channel", e.channel, got.channel);
            if (got.owner !== e.owner) report("owner", e.owner, got.owner);
            if (got.outcome !== e.outcome) report("outcome", e.outcome, got.outcome);
            if (got.elapsed !== e.elapsed) report("elapsed", e.elapsed, got.elapsed);
            if (got.session_tok !== e.session_tok)
                report("session_tok", e.session_tok, got.session_tok);
            if (got.hold_tok !== e.hold_tok) report("hold_tok", e.hold_tok, got.hold_tok);
            if (got.revision !== e.revision) report("revision", e.revision, got.revision);
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [3:0]  action = 0;
    logic [1:0]  source = 0;
    logic [7:0]  channel = 0;
    logic [31:0] session_tok = 0, hold_tok = 0, now_time_ms = 0;
    logic [2:0]  outcome_in = 0;
    logic [31:0] elapsed_in = 0;
    logic        tombstone_off = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic        accepted, lease_expired;
    logic [2:0]  decision, outcome_out;
    logic [1:0]  phase_out, owner_out;
    logic [7:0]  channel_out;
    logic [31:0] elapsed_out, session_tok_out, hold_tok_out, revision_out;

    guard_scoreboard sb;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    longint cycles = 0;
    // Scratch for the current random session, kept between items.
    logic [31:0] cur_stok = 1, cur_htok = 1, clock_ms = 0;
    logic [7:0]  cur_chan = 0;

    localparam longint CYCLE_LIMIT = 400000;

    prime_session_guard uut (.*);

    always #2 clk = ~clk;

    // Guard the run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: sample results at the rising edge, stall at the falling edge.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.accepted = accepted; got.decision = decision;
            got.lease_expired = lease_expired; got.phase = phase_out;
            got.channel = channel_out; got.owner = owner_out;
            got.outcome = outcome_out; got.elapsed = elapsed_out;
            got.session_tok = session_tok_out; got.hold_tok = hold_tok_out;
            got.revision = revision_out;
            sb.check_result(got);
        end
    end

    always @(negedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // Present one event and hold it until accepted; valid drops only on idle.
    task automatic send_event(item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        action <= it.action; source <= it.source; channel <= it.channel;
        session_tok <= it.session_tok; hold_tok <= it.hold_tok;
        now_time_ms <= it.now_time_ms; outcome_in <= it.outcome_in;
        elapsed_in <= it.elapsed_in; tombstone_off <= it.tombstone_off;
        do @(posedge clk); while (!in_ready);
        sb.note_event(it);
        @(negedge clk);
    endtask

    // Drop valid, wait for every result, let the back end settle, write the grace.
    task automatic write_grace(logic [31:0] val);
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_valid <= 1; cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.grace = val;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic item_t make_event(logic [3:0] a, logic [1:0] s, logic [7:0] c,
                                         logic [31:0] st, logic [31:0] ht,
                                         logic [31:0] now);
        item_t it;
        it.action = a; it.source = s; it.channel = c; it.session_tok = st;
        it.hold_tok = ht; it.now_time_ms = now;
        it.outcome_in = 3'($urandom_range(7));
        it.elapsed_in = $urandom; it.tombstone_off = 1'($urandom_range(1));
        return it;
    endfunction

    // Random event: mostly a coherent flow around the live session.
    function automatic item_t random_event();
        item_t it;
        int pick;
        pick = $urandom_range(99);
        clock_ms = clock_ms + (($urandom_range(9) == 0) ? $urandom : $urandom_range(2500));
        if (pick < 8)
        begin
            cur_stok = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom;
            cur_chan = 8'($urandom_range(1));
        end
        if (pick < 30 && $urandom_range(3) == 0)
            cur_htok = ($urandom_range(3) == 0) ? $urandom_range(10) : $urandom;
        it = make_event(4'($urandom_range(9)), 2'($urandom_range(1, 2)), cur_chan,
                        cur_stok, cur_htok, clock_ms);
        if (pick >= 85)
        begin
            // Noise: any field value at all.
            it.action = 4'($urandom_range(15)); it.source = 2'($urandom_range(3));
            it.channel = 8'($urandom); it.session_tok = $urandom_range(1) ? $urandom : 0;
            it.hold_tok = $urandom_range(1) ? $urandom : 0;
            it.now_time_ms = $urandom;
        end
        return it;
    endfunction

    initial
    begin
        item_t it;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: field extremes, every action, odd source and codes.
        send_event(make_event(ACT_QUERY, SRC_NONE, 0, 5, 0, 0));
        send_event(make_event(ACT_ACTIVATE, SRC_FRONT, 8'd255, 5, 1, 10));
        send_event(make_event(ACT_ACTIVATE, SRC_FRONT, 1, 0, 1, 10));
        send_event(make_event(ACT_ACTIVATE, SRC_FAUCET, 1, 32'hFFFF_FFFF, 1, 20));
        send_event(make_event(ACT_QUERY, SRC_ODD, 1, 32'hFFFF_FFFF, 0, 3020));
        send_event(make_event(ACT_HSTART, SRC_ODD, 1, 32'hFFFF_FFFF, 7, 3030));
        send_event(make_event(ACT_HSTART, SRC_FAUCET, 1, 32'hFFFF_FFFF, 7, 9000));
        send_event(make_event(ACT_PSTARTED, SRC_FAUCET, 0, 0, 7, 9001));
        send_event(make_event(ACT_HTICK, SRC_FAUCET, 1, 32'hFFFF_FFFF, 7, 9002));
        send_event(make_event(ACT_HSTART, SRC_FAUCET, 1, 32'hFFFF_FFFF, 7, 9003));
        send_event(make_event(ACT_HSTOP, SRC_FAUCET, 1, 32'hFFFF_FFFF, 7, 9004));
        it = make_event(ACT_PSTOPPED, SRC_NONE, 0, 0, 0, 9005);
        it.outcome_in = 3'd7; it.elapsed_in = 32'hFFFF_FFFF;
        send_event(it);
        send_event(make_event(ACT_HSTOP, SRC_FRONT, 1, 32'hFFFF_FFFF, 9, 9006));
        send_event(make_event(ACT_PREFUSED, SRC_NONE, 0, 0, 32'hFFFF_FFFF, 9007));
        send_event(make_event(ACT_LEASE, SRC_FRONT, 0, 0, 0, 32'hFFFF_FFFF));
        send_event(make_event(4'd15, SRC_ODD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        send_event(make_event(ACT_CANCEL, SRC_FRONT, 0, 32'hFFFF_FFFF, 0, 9010));
        it = make_event(ACT_CANCEL, SRC_FRONT, 0, 77, 0, 9011);
        it.tombstone_off = 1;
        send_event(it);
        send_event(it);
        send_event(make_event(ACT_ACTIVATE, SRC_FRONT, 0, 77, 1, 9012));
        it.tombstone_off = 0; it.session_tok = 78;
        send_event(it);

        // Random phases: three idling profiles, several grace settings.
        for (int phase_no = 0; phase_no < 3; phase_no++)
        begin
            send_idle_pct = (phase_no == 0) ? 35 : (phase_no == 1) ? 54 : 0;
            recv_idle_pct = (phase_no == 0) ? 54 : (phase_no == 1) ? 35 : 0;
            case (phase_no)
                0: write_grace(0);
                1: write_grace(32'hFFFF_FFFF);
                default: write_grace(LEASE_GRACE_RESET);
            endcase
            for (int n = 0; n < 630; n++)
            begin
                if (n == 315) write_grace($urandom_range(5000));
                send_event(random_event());
            end
        end

        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
